>>> design/sacl_pkg.sv
// Shared types, constants and codes for the set-associative cache lookup unit.
package sacl_pkg;

    localparam int ADDR_W        = 48;
    localparam int SET_IDX_W     = 8;
    localparam int WAY_OUT_W     = 2;
    localparam int CFG_W         = 4;
    localparam int CFG_IDX_W     = 2;

    localparam int WAYS_DEF      = 4;
    localparam int SETS_DEF      = 256;
    localparam int ADDR_BITS_DEF = 48;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd6;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [SET_IDX_W-1:0] set_index;
        logic                 writeback;
        logic [ADDR_W-1:0]    victim_tag;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

endpackage

>>> design/sacl_policy.sv
// Per-set hit detection, victim choice and true-LRU row update.
module sacl_policy
    import sacl_pkg::*;
#(
    parameter int WAYS = WAYS_DEF,
    parameter int AW   = ADDR_BITS_DEF
)
(
    input  logic [WAYS-1:0][AW+2+((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] row,
    input  logic [AW-1:0]                                             tag,
    input  logic                                                      is_write,
    output logic                                                      hit,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]                way,
    output logic                                                      writeback,
    output logic [AW-1:0]                                             victim_tag,
    output logic [WAYS-1:0][AW+2+((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] row_next
);

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int V_POS = WAY_W + 1;
    localparam int D_POS = WAY_W;

    logic [WAYS-1:0][AW-1:0]    tg;
    logic [WAYS-1:0]            vld;
    logic [WAYS-1:0]            drt;
    logic [WAYS-1:0][WAY_W-1:0] rk;
    logic [WAY_W-1:0]           hit_way;
    logic [WAY_W-1:0]           inv_way;
    logic [WAY_W-1:0]           lru_way;
    logic [WAY_W-1:0]           max_rank;
    logic                       found;
    logic [WAY_W-1:0]           sel_rank;

    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        found    = 1'b0;
        inv_way  = '0;
        lru_way  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            tg[w]  = row[w][AW+WAY_W+1:WAY_W+2];
            vld[w] = row[w][V_POS];
            drt[w] = row[w][D_POS];
            rk[w]  = row[w][WAY_W-1:0];
        end
        max_rank = rk[0];
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && vld[w] && tg[w] == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!found && !vld[w])
            begin
                found   = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        // ties go to the lowest way: strict compare
        for (int w = 1; w < WAYS; w++)
        begin
            if (rk[w] > max_rank)
            begin
                max_rank = rk[w];
                lru_way  = WAY_W'(w);
            end
        end

        way        = hit ? hit_way : (found ? inv_way : lru_way);
        writeback  = !hit && !found && drt[lru_way];
        victim_tag = writeback ? tg[lru_way] : '0;
        sel_rank   = rk[way];

        for (int w = 0; w < WAYS; w++)
        begin
            row_next[w] = row[w];
            if (rk[w] < sel_rank)
            begin
                row_next[w][WAY_W-1:0] = rk[w] + WAY_W'(1);
            end
            if (WAY_W'(w) == way)
            begin
                row_next[w][WAY_W-1:0] = '0;
                row_next[w][V_POS]     = 1'b1;
                row_next[w][D_POS]     = hit ? (drt[w] | is_write) : is_write;
                if (!hit)
                begin
                    row_next[w][AW+WAY_W+1:WAY_W+2] = tag;
                end
            end
        end
    end

endmodule

>>> design/set_assoc_cache_lru_lookup_unit.sv
// Top level of the set-associative write-back cache tag and true-LRU controller.
// The result is registered as ST_LOOK ends; ST_LOOK waits while a held response
// is stalled. No new access is taken until then: the set row memory is read in
// the accept cycle and written back as ST_LOOK ends, before the next read starts.
// Reset: a clearing pass writes every set row, with no access taken.
// Configuration registers reset to offset_bits 6 and index_bits 8.
module set_assoc_cache_lru_lookup_unit
    import sacl_pkg::*;
#(
    parameter int WAYS      = WAYS_DEF,
    parameter int SETS      = SETS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int MAXB  = $clog2(SETS + 1) - 1;
    localparam int ENT_W = AW + 2 + WAY_W;

    typedef logic [WAYS-1:0][ENT_W-1:0] row_t;

    state_t           state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0] offset_bits_reg;
    logic [CFG_W-1:0] index_bits_reg;

    row_t             mem [SETS];
    row_t             rdata_reg;
    row_t             clr_row;
    row_t             new_row;

    logic [AW-1:0]    addr_m;
    logic [CFG_W-1:0] ib_sat;
    logic [AW-1:0]    shifted;
    logic [SET_W:0]   set_mask;
    logic [SET_W-1:0] rd_set;
    logic [4:0]       tag_shift;
    logic [AW-1:0]    tag_in;

    logic [SET_W-1:0] set_reg;
    logic [AW-1:0]    tag_reg;
    logic             wr_reg;

    logic             accept;
    logic             look_done;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    row_t             mem_wdata;

    logic             p_hit;
    logic [WAY_W-1:0] p_way;
    logic             p_wb;
    logic [AW-1:0]    p_vtag;

    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    // address split
    always_comb
    begin
        addr_m    = req.address[AW-1:0];
        ib_sat    = (index_bits_reg > CFG_W'(MAXB)) ? CFG_W'(MAXB) : index_bits_reg;
        shifted   = addr_m >> offset_bits_reg;
        set_mask  = ((SET_W + 1)'(1) << ib_sat) - (SET_W + 1)'(1);
        rd_set    = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shift = 5'(offset_bits_reg) + 5'(ib_sat);
        tag_in    = addr_m >> tag_shift;
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            clr_row[w] = {{(AW + 2){1'b0}}, WAY_W'(w)};
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign look_done = !rsp_valid_reg || !rsp_stall;

    sacl_policy #(
        .WAYS (WAYS),
        .AW   (AW)
    ) u_policy (
        .row        (rdata_reg),
        .tag        (tag_reg),
        .is_write   (wr_reg),
        .hit        (p_hit),
        .way        (p_way),
        .writeback  (p_wb),
        .victim_tag (p_vtag),
        .row_next   (new_row)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = set_reg;
        mem_wdata    = new_row;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = clr_row;
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // hold read data until the response register is free
                if (look_done)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // set row memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= mem[rd_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= rd_set;
            tag_reg <= tag_in;
            wr_reg  <= req.is_write;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_LOOK && look_done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK && look_done)
        begin
            rsp_reg.hit        <= p_hit;
            rsp_reg.way        <= WAY_OUT_W'(p_way);
            rsp_reg.set_index  <= SET_IDX_W'(set_reg);
            rsp_reg.writeback  <= p_wb;
            rsp_reg.victim_tag <= ADDR_W'(p_vtag);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !rsp_valid_reg)
        else $error("response during clearing pass");

    a_look_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK && look_done) |=> (rsp_valid_reg && state_reg == ST_IDLE))
        else $error("lookup finished without a response");

    a_accept_starts_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOK)
        else $error("accepted transaction not looked up");

    a_wb_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.writeback) |-> !rsp_reg.hit)
        else $error("writeback reported on a hit");

    a_vtag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.writeback) |-> rsp_reg.victim_tag == '0)
        else $error("victim tag set without writeback");

endmodule
